@@ rtl/top_k_min_heap_tracker_macros.svh @@
// ----------------------------------------------------------------------------
// top_k_min_heap_tracker_macros.svh
// Assertion macros for the top-k tracker RTL.
// ----------------------------------------------------------------------------
`ifndef TOP_K_MIN_HEAP_TRACKER_MACROS_SVH
`define TOP_K_MIN_HEAP_TRACKER_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, checked on every rising clk edge outside reset.
`define TKH_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("top_k_min_heap_tracker: assertion failed");
// Next-cycle implication.
`define TKH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("top_k_min_heap_tracker: assertion failed");
`else
`define TKH_ASSERT_IMP(label, ante, cons)
`define TKH_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ rtl/tkh_pkg.sv @@
// ----------------------------------------------------------------------------
// tkh_pkg
// Sizes and helpers for the top-k min-heap tracker.
// ----------------------------------------------------------------------------
package tkh_pkg;

    localparam int HEAP_DEPTH  = 32;
    localparam int VALUE_WIDTH = 12;

    // heap index 1..HEAP_DEPTH, fill count 0..HEAP_DEPTH
    localparam int CNT_W   = $clog2(HEAP_DEPTH + 1);
    // child index 2*pos (+1) needs one more bit
    localparam int KID_W   = CNT_W + 1;
    localparam int ADDR_W  = $clog2(HEAP_DEPTH);
    localparam int TDATA_W = ((VALUE_WIDTH + 7) / 8) * 8;

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(HEAP_DEPTH);
    localparam logic [CNT_W-1:0] ROOT_POS = CNT_W'(1);

    // request kind carried on s_axis_tuser
    typedef enum logic {
        REQ_PUSH  = 1'b0,
        REQ_DRAIN = 1'b1
    } req_kind_t;

    // 1-based heap index to 0-based memory address
    function automatic logic [ADDR_W-1:0] to_addr(input logic [KID_W-1:0] idx);
        logic [KID_W-1:0] t;
        t = idx - KID_W'(1);
        return t[ADDR_W-1:0];
    endfunction

endpackage

@@ rtl/tkh_ram.sv @@
// ----------------------------------------------------------------------------
// tkh_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module tkh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        // read data holds until the next read
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ rtl/top_k_min_heap_tracker.sv @@
// A push into a non-full heap sifts up level by level; a push into a full heap compares
//   with the root and then sifts down level by level; a drain hands out each value and
//   then sifts down, and can also wait on m_axis_tready.
// Items are taken one at a time, in the idle cycle after the sequencer ends; the single
//   heap read port sets the pace.
// Reset: rst_n async active low clears fill count, sequencer and output valid only.
// ----------------------------------------------------------------------------
// top_k_min_heap_tracker
// Keeps the HEAP_DEPTH largest samples in a 1-based binary min-heap held in a
// RAM. A small sequencer walks sift-up / sift-down one level at a time using a
// single read port and a single comparator path. Sifts move a "hole" instead of
// swapping: the moving value stays in a register and is written once at the end.
// A drain pops the root repeatedly, emitting values in ascending order.
// ----------------------------------------------------------------------------
`include "top_k_min_heap_tracker_macros.svh"

module top_k_min_heap_tracker (
    input  logic                        clk,
    input  logic                        rst_n,
    // input items
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [tkh_pkg::TDATA_W-1:0] s_axis_tdata,  // [11:0] sample_value, rest zero
    input  logic                        s_axis_tuser,  // [0] req_type (0 push, 1 drain)
    // result items
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [tkh_pkg::TDATA_W-1:0] m_axis_tdata,  // [11:0] out_value, rest zero
    output logic                        m_axis_tuser,  // [0] out_valid
    output logic                        m_axis_tlast   // out_last
);

    localparam int CW = tkh_pkg::CNT_W;
    localparam int KW = tkh_pkg::KID_W;
    localparam int VW = tkh_pkg::VALUE_WIDTH;
    localparam int AW = tkh_pkg::ADDR_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EMPTY,       // drain of an empty heap: one flagged-invalid item
        ST_UP_CHK,      // sift-up: stop at root or fetch parent
        ST_UP_CMP,      // sift-up: compare with parent
        ST_ROOT_CMP,    // full heap push: compare with root
        ST_DN_CHK,      // sift-down: stop at leaf or fetch left child
        ST_DN_L,        // sift-down: left child data, fetch right child if any
        ST_DN_R,        // sift-down: pick smaller child
        ST_DN_CMP,      // sift-down: compare smaller child with moving value
        ST_POP_START,   // drain: fetch root or finish
        ST_POP_EMIT,    // drain: hand root to output, fetch last entry
        ST_POP_LAST     // drain: last entry becomes moving value at root
    } state_t;

    state_t          state_reg, state_next;
    logic            drain_reg, drain_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [CW-1:0]   pos_reg, pos_next;
    logic [KW-1:0]   kid_reg, kid_next;
    logic [KW-1:0]   ckid_reg, ckid_next;
    logic [VW-1:0]   mv_reg, mv_next;
    logic [VW-1:0]   lval_reg, lval_next;
    logic [VW-1:0]   cval_reg, cval_next;
    logic            m_valid_reg, m_valid_next;
    logic [VW-1:0]   m_value_reg, m_value_next;
    logic            m_flag_reg, m_flag_next;
    logic            m_last_reg, m_last_next;

    // heap memory port signals
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic [VW-1:0]   wr_data;
    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    logic [VW-1:0]   rd_data;

    logic            out_free;
    logic [KW-1:0]   pos_ext;
    logic [KW-1:0]   cnt_ext;
    logic [KW-1:0]   left_kid;
    state_t          done_state;

    tkh_ram #(
        .WIDTH (VW),
        .DEPTH (tkh_pkg::HEAP_DEPTH)
    ) u_heap_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign out_free   = !m_valid_reg || m_axis_tready;
    assign pos_ext    = {1'b0, pos_reg};
    assign cnt_ext    = {1'b0, cnt_reg};
    assign left_kid   = {pos_reg, 1'b0};
    // a finished sift returns to the drain loop or to idle
    assign done_state = drain_reg ? ST_POP_START : ST_IDLE;

    always_comb
    begin
        state_next   = state_reg;
        drain_next   = drain_reg;
        cnt_next     = cnt_reg;
        pos_next     = pos_reg;
        kid_next     = kid_reg;
        ckid_next    = ckid_reg;
        mv_next      = mv_reg;
        lval_next    = lval_reg;
        cval_next    = cval_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        m_value_next = m_value_reg;
        m_flag_next  = m_flag_reg;
        m_last_next  = m_last_reg;
        wr_en        = 1'b0;
        wr_addr      = tkh_pkg::to_addr(pos_ext);
        wr_data      = mv_reg;
        rd_en        = 1'b0;
        rd_addr      = tkh_pkg::to_addr(KW'(1));

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    mv_next    = s_axis_tdata[VW-1:0];
                    drain_next = (s_axis_tuser == tkh_pkg::REQ_DRAIN);
                    if (s_axis_tuser == tkh_pkg::REQ_DRAIN)
                    begin
                        state_next = (cnt_reg == '0) ? ST_EMPTY : ST_POP_START;
                    end
                    else if (cnt_reg < tkh_pkg::FULL_CNT)
                    begin
                        cnt_next   = cnt_reg + CW'(1);
                        pos_next   = cnt_reg + CW'(1);
                        state_next = ST_UP_CHK;
                    end
                    else
                    begin
                        rd_en      = 1'b1;   // root
                        state_next = ST_ROOT_CMP;
                    end
                end
            end

            ST_EMPTY:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_value_next = '0;
                    m_flag_next  = 1'b0;
                    m_last_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            ST_UP_CHK:
            begin
                if (pos_reg == tkh_pkg::ROOT_POS)
                begin
                    wr_en      = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = tkh_pkg::to_addr({2'b00, pos_reg[CW-1:1]});
                    state_next = ST_UP_CMP;
                end
            end

            ST_UP_CMP:
            begin
                wr_en = 1'b1;
                if (mv_reg < rd_data)
                begin
                    // parent moves down into the hole
                    wr_data    = rd_data;
                    pos_next   = pos_reg >> 1;
                    state_next = ST_UP_CHK;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_ROOT_CMP:
            begin
                if (mv_reg > rd_data)
                begin
                    pos_next   = tkh_pkg::ROOT_POS;
                    state_next = ST_DN_CHK;
                end
                else
                begin
                    state_next = ST_IDLE;    // sample dropped
                end
            end

            ST_DN_CHK:
            begin
                if (left_kid > cnt_ext)
                begin
                    wr_en      = 1'b1;
                    state_next = done_state;
                end
                else
                begin
                    kid_next   = left_kid;
                    rd_en      = 1'b1;
                    rd_addr    = tkh_pkg::to_addr(left_kid);
                    state_next = ST_DN_L;
                end
            end

            ST_DN_L:
            begin
                if (kid_reg < cnt_ext)
                begin
                    lval_next  = rd_data;
                    rd_en      = 1'b1;
                    rd_addr    = tkh_pkg::to_addr(kid_reg + KW'(1));
                    state_next = ST_DN_R;
                end
                else
                begin
                    cval_next  = rd_data;
                    ckid_next  = kid_reg;
                    state_next = ST_DN_CMP;
                end
            end

            ST_DN_R:
            begin
                // right child wins only when strictly smaller
                if (lval_reg > rd_data)
                begin
                    cval_next = rd_data;
                    ckid_next = kid_reg + KW'(1);
                end
                else
                begin
                    cval_next = lval_reg;
                    ckid_next = kid_reg;
                end
                state_next = ST_DN_CMP;
            end

            ST_DN_CMP:
            begin
                wr_en = 1'b1;
                if (cval_reg < mv_reg)
                begin
                    wr_data    = cval_reg;
                    pos_next   = ckid_reg[CW-1:0];
                    state_next = ST_DN_CHK;
                end
                else
                begin
                    state_next = done_state;
                end
            end

            ST_POP_START:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    rd_en      = 1'b1;   // root
                    state_next = ST_POP_EMIT;
                end
            end

            ST_POP_EMIT:
            begin
                // rd_data holds the root until the output slot frees up
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_value_next = rd_data;
                    m_flag_next  = 1'b1;
                    m_last_next  = (cnt_reg == CW'(1));
                    rd_en        = 1'b1;
                    rd_addr      = tkh_pkg::to_addr(cnt_ext);
                    state_next   = ST_POP_LAST;
                end
            end

            ST_POP_LAST:
            begin
                mv_next    = rd_data;
                cnt_next   = cnt_reg - CW'(1);
                pos_next   = tkh_pkg::ROOT_POS;
                state_next = ST_DN_CHK;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            drain_reg   <= 1'b0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            drain_reg   <= drain_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        kid_reg     <= kid_next;
        ckid_reg    <= ckid_next;
        mv_reg      <= mv_next;
        lval_reg    <= lval_next;
        cval_reg    <= cval_next;
        m_value_reg <= m_value_next;
        m_flag_reg  <= m_flag_next;
        m_last_reg  <= m_last_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_flag_reg;
    assign m_axis_tlast  = m_last_reg;

    always_comb
    begin
        m_axis_tdata         = '0;
        m_axis_tdata[VW-1:0] = m_value_reg;
    end

    // fill count stays within the heap
    `TKH_ASSERT_IMP(a_cnt_range, 1'b1, cnt_reg <= tkh_pkg::FULL_CNT)
    // an empty-drain item is always the last of its run
    `TKH_ASSERT_IMP(a_empty_last, m_valid_reg && !m_flag_reg, m_last_reg)
    // chosen child lies inside the heap and below the hole
    `TKH_ASSERT_IMP(a_kid_range, state_reg == ST_DN_CMP, ckid_reg <= cnt_ext && ckid_reg > pos_ext)
    // drain loop ends in idle once the heap is empty
    `TKH_ASSERT_NEXT(a_drain_end, state_reg == ST_POP_START && cnt_reg == '0, state_reg == ST_IDLE)

endmodule
